// ----- hdl/jsu_pkg.sv -----
// ---------------------------------------------------------------------------
// jsu_pkg
// types, codes and helpers shared by the json string unescaper
// ---------------------------------------------------------------------------
package jsu_pkg;

    // stream widths
    localparam int UNIT_W     = 16;
    localparam int CODE_W     = 3;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - UNIT_W - CODE_W;

    // default result queue depth (power of two, at least 4)
    localparam int FIFO_DEPTH = 4;

    // characters of interest
    localparam logic [UNIT_W-1:0] CH_QUOTE  = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_BS     = 16'h0008;
    localparam logic [UNIT_W-1:0] CH_FF     = 16'h000C;
    localparam logic [UNIT_W-1:0] CH_LOW_B  = 16'h0062;
    localparam logic [UNIT_W-1:0] CH_LOW_F  = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_LOW_N  = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_LOW_R  = 16'h0072;
    localparam logic [UNIT_W-1:0] CH_LOW_T  = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_LOW_U  = 16'h0075;
    localparam logic [UNIT_W-1:0] CTRL_MAX  = 16'h001F;

    // surrogate ranges
    localparam logic [UNIT_W-1:0] HI_SURR_MIN = 16'hD800;
    localparam logic [UNIT_W-1:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [UNIT_W-1:0] LO_SURR_MAX = 16'hDFFF;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_BS2  = 3'd4,
        MODE_U2   = 3'd5,
        MODE_HEX2 = 3'd6
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNIT = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_EXP_STR   = 3'd1,
        ERR_BAD_ESC   = 3'd2,
        ERR_BAD_UESC  = 3'd3,
        ERR_BAD_SURR  = 3'd4,
        ERR_CTRL_CHAR = 3'd5,
        ERR_UNTERM    = 3'd6
    } err_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        kind_t             kind;
        err_t              code;
        logic              last;
    } result_t;

    // what one input item produces
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    function automatic result_t mk_unit(logic [UNIT_W-1:0] unit, logic last);
        result_t r;
        r.unit = unit;
        r.kind = KIND_UNIT;
        r.code = ERR_NONE;
        r.last = last;
        return r;
    endfunction

    function automatic result_t mk_end();
        result_t r;
        r.unit = '0;
        r.kind = KIND_END;
        r.code = ERR_NONE;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_err(err_t code);
        result_t r;
        r.unit = '0;
        r.kind = KIND_ERR;
        r.code = code;
        r.last = 1'b1;
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(logic [UNIT_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                     (c >= 16'h0041 && c <= 16'h0046)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ----- hdl/json_string_unescaper.sv -----
// ---------------------------------------------------------------------------
// json_string_unescaper
// unescapes json strings given as utf-16 code units, one unit per request
// ---------------------------------------------------------------------------
//
//  channel  | dir | fields
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata: code_unit[15:0]; tuser: end_of_text
//  m_axis   | out | tdata: out_unit[15:0], error_code[18:16]; tuser:
//           |     | result_kind[1:0]; tlast: last_of_run
//
//  one input request per cycle while s_axis_tready is high; a result passes
//  through the input register, then the parser into the result queue
//  a decoded surrogate pair yields two results, drained from the result
//  queue one per cycle while m_axis_tready is high; that queue port sets the sustained output rate
//  aresetn (synchronous, active low) returns the parser to idle, empties
//  the queue and drops any held input request
//  s_axis_tready falls only when the input register is held and the queue
//  has fewer than two free slots; output stalls never reach the input
//  combinationally
//
module json_string_unescaper #(
    parameter int FIFO_DEPTH = jsu_pkg::FIFO_DEPTH   // power of two, at least 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input requests
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [jsu_pkg::S_TDATA_W-1:0] s_axis_tdata,  // code_unit
    input  logic                         s_axis_tuser,  // end_of_text
    // results
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [jsu_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_unit, error_code, zero pad
    output logic [jsu_pkg::KIND_W-1:0]   m_axis_tuser,  // result_kind
    output logic                         m_axis_tlast   // last_of_run
);
    import jsu_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [UNIT_W-1:0] in_unit_reg;
    logic              in_eot_reg;

    logic              advance;
    logic              fifo_room;
    dec_out_t          dec;
    dec_out_t          push;
    result_t           head;

    // the held request moves on when the queue can take a pair
    assign advance       = in_valid_reg && fifo_room;
    assign s_axis_tready = !in_valid_reg || fifo_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_unit_reg <= s_axis_tdata[UNIT_W-1:0];
            in_eot_reg  <= s_axis_tuser;
        end
    end

    jsu_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (advance),
        .in_unit  (in_unit_reg),
        .in_eot   (in_eot_reg),
        .dec      (dec)
    );

    // nothing is queued unless the request really advances
    always_comb begin
        push       = dec;
        push.count = advance ? dec.count : 2'd0;
    end

    jsu_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (fifo_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, head.code, head.unit};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

// ----- hdl/jsu_parser.sv -----
// ---------------------------------------------------------------------------
// jsu_parser
// parse state machine and escape decoding for one code unit per cycle while in_valid is high
// ---------------------------------------------------------------------------
module jsu_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [jsu_pkg::UNIT_W-1:0] in_unit,
    input  logic                      in_eot,
    output jsu_pkg::dec_out_t         dec
);
    import jsu_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [UNIT_W-1:0] hex_value_reg, hex_value_next;
    logic [1:0]        digit_count_reg, digit_count_next;
    logic [UNIT_W-1:0] high_unit_reg, high_unit_next;

    logic [4:0]        hd;
    logic              hex_ok;
    logic              last_digit;
    logic [UNIT_W-1:0] hex_full;
    logic              full_hi, full_lo;
    logic              is_ws;

    assign hd         = hex_decode(in_unit);
    assign hex_ok     = !in_eot && hd[4];
    assign last_digit = (digit_count_reg == 2'd3);
    assign hex_full   = {hex_value_reg[UNIT_W-5:0], hd[3:0]};
    assign full_hi    = (hex_full >= HI_SURR_MIN) && (hex_full <= HI_SURR_MAX);
    assign full_lo    = (hex_full >= LO_SURR_MIN) && (hex_full <= LO_SURR_MAX);
    assign is_ws      = (in_unit == CH_SPACE) || (in_unit == CH_TAB) ||
                        (in_unit == CH_CR) || (in_unit == CH_LF);

    // next state
    always_comb begin
        mode_next = MODE_IDLE;
        unique case (mode_reg)
            MODE_STR: begin
                if (in_eot || in_unit == CH_QUOTE || in_unit <= CTRL_MAX) begin
                    mode_next = MODE_IDLE;
                end else if (in_unit == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_STR;
                end
            end
            MODE_ESC: begin
                if (in_eot) begin
                    mode_next = MODE_IDLE;
                end else if (in_unit == CH_LOW_U) begin
                    mode_next = MODE_HEX1;
                end else if (in_unit == CH_QUOTE || in_unit == CH_BSLASH ||
                             in_unit == CH_SLASH || in_unit == CH_LOW_B ||
                             in_unit == CH_LOW_F || in_unit == CH_LOW_N ||
                             in_unit == CH_LOW_R || in_unit == CH_LOW_T) begin
                    mode_next = MODE_STR;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_HEX1: begin
                if (!hex_ok) begin
                    mode_next = MODE_IDLE;
                end else if (!last_digit) begin
                    mode_next = MODE_HEX1;
                end else if (full_hi) begin
                    mode_next = MODE_BS2;
                end else if (full_lo) begin
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = MODE_STR;
                end
            end
            MODE_HEX2: begin
                if (!hex_ok) begin
                    mode_next = MODE_IDLE;
                end else if (!last_digit) begin
                    mode_next = MODE_HEX2;
                end else if (full_lo) begin
                    mode_next = MODE_STR;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BS2: begin
                mode_next = (!in_eot && in_unit == CH_BSLASH) ? MODE_U2 : MODE_IDLE;
            end
            MODE_U2: begin
                mode_next = (!in_eot && in_unit == CH_LOW_U) ? MODE_HEX2 : MODE_IDLE;
            end
            default: begin
                mode_next = (!in_eot && in_unit == CH_QUOTE) ? MODE_STR : MODE_IDLE;
            end
        endcase
    end

    // hex gathering and held high surrogate
    always_comb begin
        hex_value_next   = hex_value_reg;
        digit_count_next = digit_count_reg;
        high_unit_next   = high_unit_reg;
        if (mode_reg == MODE_ESC || mode_reg == MODE_U2) begin
            digit_count_next = '0;
        end else if ((mode_reg == MODE_HEX1 || mode_reg == MODE_HEX2) && hex_ok) begin
            hex_value_next   = hex_full;
            digit_count_next = last_digit ? 2'd0 : 2'(digit_count_reg + 2'd1);
            if (mode_reg == MODE_HEX1 && last_digit && full_hi) begin
                high_unit_next = hex_full;
            end
        end
    end

    // results
    always_comb begin
        dec.count = 2'd0;
        dec.res0  = mk_end();
        dec.res1  = mk_end();
        unique case (mode_reg)
            MODE_STR: begin
                dec.count = 2'd1;
                if (in_eot) begin
                    dec.res0 = mk_err(ERR_UNTERM);
                end else if (in_unit == CH_QUOTE) begin
                    dec.res0 = mk_end();
                end else if (in_unit == CH_BSLASH) begin
                    dec.count = 2'd0;
                end else if (in_unit <= CTRL_MAX) begin
                    dec.res0 = mk_err(ERR_CTRL_CHAR);
                end else begin
                    dec.res0 = mk_unit(in_unit, 1'b1);
                end
            end
            MODE_ESC: begin
                dec.count = 2'd1;
                dec.res0  = mk_err(ERR_BAD_ESC);
                if (!in_eot) begin
                    priority if (in_unit == CH_QUOTE || in_unit == CH_BSLASH ||
                                 in_unit == CH_SLASH) begin
                        dec.res0 = mk_unit(in_unit, 1'b1);
                    end else if (in_unit == CH_LOW_B) begin
                        dec.res0 = mk_unit(CH_BS, 1'b1);
                    end else if (in_unit == CH_LOW_F) begin
                        dec.res0 = mk_unit(CH_FF, 1'b1);
                    end else if (in_unit == CH_LOW_N) begin
                        dec.res0 = mk_unit(CH_LF, 1'b1);
                    end else if (in_unit == CH_LOW_R) begin
                        dec.res0 = mk_unit(CH_CR, 1'b1);
                    end else if (in_unit == CH_LOW_T) begin
                        dec.res0 = mk_unit(CH_TAB, 1'b1);
                    end else if (in_unit == CH_LOW_U) begin
                        dec.count = 2'd0;
                    end else begin
                        dec.res0 = mk_err(ERR_BAD_ESC);
                    end
                end
            end
            MODE_HEX1: begin
                if (in_eot) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_UESC);
                end else if (!hd[4]) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_UESC);
                end else if (last_digit && full_lo) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_SURR);
                end else if (last_digit && !full_hi) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_unit(hex_full, 1'b1);
                end
            end
            MODE_HEX2: begin
                if (in_eot) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_SURR);
                end else if (!hd[4]) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_UESC);
                end else if (last_digit && !full_lo) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_SURR);
                end else if (last_digit) begin
                    // surrogate pair goes out as high then low
                    dec.count = 2'd2;
                    dec.res0  = mk_unit(high_unit_reg, 1'b0);
                    dec.res1  = mk_unit(hex_full, 1'b1);
                end
            end
            MODE_BS2: begin
                if (in_eot || in_unit != CH_BSLASH) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_SURR);
                end
            end
            MODE_U2: begin
                if (in_eot || in_unit != CH_LOW_U) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_BAD_SURR);
                end
            end
            default: begin
                if (!in_eot && !is_ws && in_unit != CH_QUOTE) begin
                    dec.count = 2'd1;
                    dec.res0  = mk_err(ERR_EXP_STR);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            digit_count_reg <= '0;
        end else if (in_valid) begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            hex_value_reg <= hex_value_next;
            high_unit_reg <= high_unit_next;
        end
    end

    // a pair only completes the second escape
    a_pair_from_hex2: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && dec.count == 2'd2) |-> (mode_reg == MODE_HEX2))
        else $error("surrogate pair outside second escape");

    // an error or a closing quote always drops back to idle
    a_err_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && dec.count != 2'd0 &&
         (dec.res0.kind == KIND_ERR || dec.res0.kind == KIND_END))
        |=> (mode_reg == MODE_IDLE))
        else $error("no return to idle after error or end");

    // only the final result of an item carries last
    a_last_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && dec.count == 2'd2) |-> (!dec.res0.last && dec.res1.last))
        else $error("pair last flags wrong");

endmodule

// ----- hdl/jsu_result_fifo.sv -----
// ---------------------------------------------------------------------------
// jsu_result_fifo
// small result queue, takes up to two results per cycle while room is high, gives one when out_ready is high
// ---------------------------------------------------------------------------
module jsu_result_fifo #(
    parameter int DEPTH = jsu_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  jsu_pkg::dec_out_t push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output jsu_pkg::result_t out_res
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push.count) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= push.res1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("push without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 && push.count == 2'd0) |=> (count_reg == '0))
        else $error("count moved without traffic");

endmodule
